// ===== hdl/sat_pkg.sv =====
// Shared types and constants for the segment address translator.
`timescale 1ns / 1ps
`default_nettype none

package sat_pkg;

   // fault codes, first failing check wins
   localparam logic [2:0] FLT_OK     = 3'd0;
   localparam logic [2:0] FLT_TABLE  = 3'd1;
   localparam logic [2:0] FLT_WRITE  = 3'd2;
   localparam logic [2:0] FLT_EXEC   = 3'd3;
   localparam logic [2:0] FLT_PRIV   = 3'd4;
   localparam logic [2:0] FLT_SEGLIM = 3'd5;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROTECTED_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GDT_BASE       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GDT_LIMIT      = 2'd2;

   // selector field positions
   localparam int SEL_TABLE_BIT = 2;

   // descriptor granularity scaling
   localparam int         GRAN_SHIFT = 12;
   localparam logic [11:0] GRAN_FILL = 12'hFFF;

   typedef struct packed {
      logic [15:0] selector;
      logic [31:0] offset;
      logic        is_write;
      logic [15:0] code_selector;
      logic [31:0] descriptor_low;
      logic [31:0] descriptor_high;
   } req_item_type;

   typedef struct packed {
      logic [31:0] linear_address;
      logic [31:0] entry_address;
      logic        local_table;
      logic [2:0]  fault_code;
   } rsp_item_type;

   typedef struct packed {
      logic        protected_mode;
      logic [31:0] gdt_base;
      logic [15:0] gdt_limit;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hdl/sat_req_if.sv =====
// Request channel: valid/ready handshake carrying one translation item.
`timescale 1ns / 1ps
`default_nettype none

interface sat_req_if;
   logic                  valid;
   logic                  ready;
   sat_pkg::req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/sat_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one translated item.
`timescale 1ns / 1ps
`default_nettype none

interface sat_rsp_if;
   logic                  valid;
   logic                  ready;
   sat_pkg::rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/sat_csr.sv =====
// Configuration registers: mode, table base and table limit.
`timescale 1ns / 1ps
`default_nettype none

module sat_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [sat_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [sat_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output sat_pkg::cfg_type                      cfg
);

   sat_pkg::cfg_type cfg_ff;
   sat_pkg::cfg_type cfg_in;

   // decode a write; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            sat_pkg::CSR_PROTECTED_MODE: cfg_in.protected_mode = csr_wdata[0];
            sat_pkg::CSR_GDT_BASE:       cfg_in.gdt_base       = csr_wdata[31:0];
            sat_pkg::CSR_GDT_LIMIT:      cfg_in.gdt_limit      = csr_wdata[15:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hdl/segment_address_translator.sv =====
// Segment address translator: three-stage pipeline from selector/offset to linear address.
// A taken request passes through the decode, compare/add and fault-select stage registers in that
// order before its response is valid.
// Throughput: one item per cycle; each stage advances when the stage after it is empty or
// moving, so a stalled response holds the pipeline without loss and bubbles are squeezed out.
// Reset clears all stage valid bits and the configuration registers (real mode, base 0,
// limit 0); there is no clearing pass and requests are taken in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module segment_address_translator (
   input  wire logic                             clock,
   input  wire logic                             reset,
   sat_req_if.sink                               req_chan,
   sat_rsp_if.source                             rsp_chan,
   input  wire logic                             csr_we,
   input  wire logic [sat_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [sat_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   sat_pkg::cfg_type cfg;

   sat_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // stage enables, back to front
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in;
   logic s1_en, s2_en, s3_en;

   assign s3_en = !s3_valid_ff || rsp_chan.ready;
   assign s2_en = !s2_valid_ff || s3_en;
   assign s1_en = !s1_valid_ff || s2_en;
   assign req_chan.ready = s1_en;

   assign s1_valid_in = s1_en ? req_chan.valid : s1_valid_ff;
   assign s2_valid_in = s2_en ? s1_valid_ff    : s2_valid_ff;
   assign s3_valid_in = s3_en ? s2_valid_ff    : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // ---------------- stage 1: decode selector and descriptor ----------------
   sat_pkg::req_item_type req;
   logic [7:0]  acc_byte;
   logic [19:0] raw_limit;
   logic        desc_path;

   logic        s1_pm_ff, s1_pm_in;
   logic        s1_ltab_ff, s1_ltab_in;
   logic [31:0] s1_ent_ff, s1_ent_in;
   logic [31:0] s1_bound_ff, s1_bound_in;
   logic        s1_wr_ff, s1_wr_in;
   logic        s1_ex_ff, s1_ex_in;
   logic        s1_priv_ff, s1_priv_in;
   logic [31:0] s1_dbase_ff, s1_dbase_in;
   logic [31:0] s1_dlimit_ff, s1_dlimit_in;
   logic [31:0] s1_off_ff, s1_off_in;
   logic [15:0] s1_sel_ff, s1_sel_in;

   assign req = req_chan.payload;

   always_comb begin
      acc_byte   = req.descriptor_high[15:8];
      raw_limit  = {req.descriptor_high[19:16], req.descriptor_low[15:0]};
      s1_pm_in   = cfg.protected_mode;
      s1_ltab_in = cfg.protected_mode && req.selector[sat_pkg::SEL_TABLE_BIT];
      desc_path  = cfg.protected_mode && !req.selector[sat_pkg::SEL_TABLE_BIT];
      // descriptor location, zero outside the descriptor path
      s1_ent_in  = desc_path ? (cfg.gdt_base + {16'd0, req.selector[15:3], 3'd0}) : 32'd0;
      s1_bound_in = cfg.gdt_base + {16'd0, cfg.gdt_limit} + 32'd1;
      s1_wr_in   = req.is_write && !acc_byte[1];
      s1_ex_in   = (req.selector == req.code_selector) && !acc_byte[3];
      s1_priv_in = acc_byte[6:5] < req.selector[1:0];
      s1_dbase_in = {req.descriptor_high[31:24], req.descriptor_high[7:0],
                     req.descriptor_low[31:16]};
      // granularity bit scales the limit to 4 KiB units
      if (req.descriptor_high[23]) begin
         s1_dlimit_in = {raw_limit, sat_pkg::GRAN_FILL};
      end else begin
         s1_dlimit_in = {12'd0, raw_limit};
      end
      s1_off_in  = req.offset;
      s1_sel_in  = req.selector;
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_pm_ff     <= s1_pm_in;
         s1_ltab_ff   <= s1_ltab_in;
         s1_ent_ff    <= s1_ent_in;
         s1_bound_ff  <= s1_bound_in;
         s1_wr_ff     <= s1_wr_in;
         s1_ex_ff     <= s1_ex_in;
         s1_priv_ff   <= s1_priv_in;
         s1_dbase_ff  <= s1_dbase_in;
         s1_dlimit_ff <= s1_dlimit_in;
         s1_off_ff    <= s1_off_in;
         s1_sel_ff    <= s1_sel_in;
      end
   end

   // ---------------- stage 2: bound compares and address add ----------------
   logic        s2_pm_ff, s2_ltab_ff;
   logic [31:0] s2_ent_ff;
   logic        s2_tbl_ff, s2_tbl_in;
   logic        s2_wr_ff, s2_ex_ff, s2_priv_ff;
   logic        s2_seg_ff, s2_seg_in;
   logic [31:0] s2_sum_ff, s2_sum_in;

   always_comb begin
      s2_tbl_in = s1_ent_ff > s1_bound_ff;
      s2_seg_in = s1_off_ff > s1_dlimit_ff;
      // real mode uses selector times 16 as the base
      if (s1_pm_ff) begin
         s2_sum_in = s1_dbase_ff + s1_off_ff;
      end else begin
         s2_sum_in = {12'd0, s1_sel_ff, 4'd0} + s1_off_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_pm_ff   <= s1_pm_ff;
         s2_ltab_ff <= s1_ltab_ff;
         s2_ent_ff  <= s1_ent_ff;
         s2_tbl_ff  <= s2_tbl_in;
         s2_wr_ff   <= s1_wr_ff;
         s2_ex_ff   <= s1_ex_ff;
         s2_priv_ff <= s1_priv_ff;
         s2_seg_ff  <= s2_seg_in;
         s2_sum_ff  <= s2_sum_in;
      end
   end

   // ---------------- stage 3: fault priority and result register ----------------
   sat_pkg::rsp_item_type s3_rsp_ff, s3_rsp_in;
   logic [2:0] flt;

   always_comb begin
      if (!s2_pm_ff || s2_ltab_ff) begin
         flt = sat_pkg::FLT_OK;
      end else if (s2_tbl_ff) begin
         flt = sat_pkg::FLT_TABLE;
      end else if (s2_wr_ff) begin
         flt = sat_pkg::FLT_WRITE;
      end else if (s2_ex_ff) begin
         flt = sat_pkg::FLT_EXEC;
      end else if (s2_priv_ff) begin
         flt = sat_pkg::FLT_PRIV;
      end else if (s2_seg_ff) begin
         flt = sat_pkg::FLT_SEGLIM;
      end else begin
         flt = sat_pkg::FLT_OK;
      end
      s3_rsp_in.fault_code     = flt;
      s3_rsp_in.local_table    = s2_ltab_ff;
      s3_rsp_in.entry_address  = s2_ent_ff;
      s3_rsp_in.linear_address = (s2_ltab_ff || flt != sat_pkg::FLT_OK) ? 32'd0 : s2_sum_ff;
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_rsp_ff <= s3_rsp_in;
      end
   end

   assign rsp_chan.valid   = s3_valid_ff;
   assign rsp_chan.payload = s3_rsp_ff;

   // ---------------- checks ----------------
   // an accepted item always lands in stage 1
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> s1_valid_ff)
      else $error("accepted item did not reach stage 1");

   // fault codes stay within the defined set
   a_fault_range: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (s3_rsp_ff.fault_code <= sat_pkg::FLT_SEGLIM))
      else $error("fault code out of range");

   // a faulted or local-table item never carries an address
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && (s3_rsp_ff.fault_code != sat_pkg::FLT_OK || s3_rsp_ff.local_table))
      |-> (s3_rsp_ff.linear_address == 32'd0))
      else $error("faulted item has nonzero linear address");

   // local-table items never report a fault or a descriptor location
   a_local_clean: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_rsp_ff.local_table)
      |-> (s3_rsp_ff.fault_code == sat_pkg::FLT_OK && s3_rsp_ff.entry_address == 32'd0))
      else $error("local-table item carries fault or entry address");

endmodule

`default_nettype wire
